### design/eight_bit_alu_with_flags_top_defines.svh
// Assertion macros for the eight-bit ALU top module.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_TOP_DEFINES_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EBALU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EBALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ebalu_pkg.sv
// Types and constants for the eight-bit ALU with flags.
package ebalu_pkg;

  typedef enum logic [4:0] {
    CMD_ADD  = 5'd0,
    CMD_ADC  = 5'd1,
    CMD_SUB  = 5'd2,
    CMD_SBC  = 5'd3,
    CMD_AND  = 5'd4,
    CMD_OR   = 5'd5,
    CMD_XOR  = 5'd6,
    CMD_CP   = 5'd7,
    CMD_INC  = 5'd8,
    CMD_DEC  = 5'd9,
    CMD_RLC  = 5'd10,
    CMD_RRC  = 5'd11,
    CMD_RL   = 5'd12,
    CMD_RR   = 5'd13,
    CMD_SLA  = 5'd14,
    CMD_SRA  = 5'd15,
    CMD_SRL  = 5'd16,
    CMD_SWAP = 5'd17,
    CMD_BIT  = 5'd18,
    CMD_SET  = 5'd19,
    CMD_RES  = 5'd20,
    CMD_DAA  = 5'd21,
    CMD_CPL  = 5'd22,
    CMD_CCF  = 5'd23,
    CMD_SCF  = 5'd24,
    CMD_RLCA = 5'd25,
    CMD_RRCA = 5'd26,
    CMD_RLA  = 5'd27,
    CMD_RRA  = 5'd28
  } cmd_t;

  // Positions of the flags in the byte.
  localparam int unsigned FLAG_Z = 7;
  localparam int unsigned FLAG_N = 6;
  localparam int unsigned FLAG_H = 5;
  localparam int unsigned FLAG_C = 4;

  localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
  localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
  localparam logic [7:0] DAA_LIMIT    = 8'h99;
  localparam logic [3:0] DIGIT_MAX    = 4'd9;

  // Result of one operation, flags held as four bits {Z, N, H, C}.
  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags;
    logic       write_back;
  } alu_res_t;

endpackage

### design/ebalu_core.sv
// Combinational datapath of the eight-bit ALU: arithmetic, logic, shifts and flags.
module ebalu_core (
  input  logic [4:0]        command,
  input  logic [7:0]        accumulator,
  input  logic [7:0]        operand_value,
  input  logic [7:0]        flags_in,
  input  logic [2:0]        bit_index,
  output ebalu_pkg::alu_res_t res
);

  logic       cin;
  logic       fin_n;
  logic       fin_h;
  logic       use_cin;
  logic [8:0] sum9;
  logic [4:0] sum_lo;
  logic [8:0] diff9;
  logic [4:0] diff_lo;
  logic [7:0] daa_adj;
  logic       daa_carry;
  logic [7:0] rot_src;
  logic [7:0] bit_mask;
  logic [7:0] r;
  logic       fz;
  logic       fn;
  logic       fh;
  logic       fc;
  logic       wb;
  logic       zcalc;

  assign cin   = flags_in[ebalu_pkg::FLAG_C];
  assign fin_n = flags_in[ebalu_pkg::FLAG_N];
  assign fin_h = flags_in[ebalu_pkg::FLAG_H];

  assign use_cin = (command == ebalu_pkg::CMD_ADC || command == ebalu_pkg::CMD_SBC) ? cin
                                                                                     : 1'b0;

  assign sum9    = {1'b0, accumulator} + {1'b0, operand_value} + {8'd0, use_cin};
  assign sum_lo  = {1'b0, accumulator[3:0]} + {1'b0, operand_value[3:0]} + {4'd0, use_cin};
  assign diff9   = {1'b0, accumulator} - {1'b0, operand_value} - {8'd0, use_cin};
  assign diff_lo = {1'b0, accumulator[3:0]} - {1'b0, operand_value[3:0]} - {4'd0, use_cin};

  // Decimal adjust: after an addition the carry may also be raised when the accumulator exceeds 0x99.
  always_comb begin
    daa_adj   = 8'h00;
    daa_carry = cin;
    if (!fin_n) begin
      if (cin || accumulator > ebalu_pkg::DAA_LIMIT) begin
        daa_adj   = daa_adj | ebalu_pkg::DAA_HIGH_ADJ;
        daa_carry = 1'b1;
      end
      if (fin_h || accumulator[3:0] > ebalu_pkg::DIGIT_MAX) begin
        daa_adj = daa_adj | ebalu_pkg::DAA_LOW_ADJ;
      end
    end else begin
      if (cin) begin
        daa_adj = daa_adj | ebalu_pkg::DAA_HIGH_ADJ;
      end
      if (fin_h) begin
        daa_adj = daa_adj | ebalu_pkg::DAA_LOW_ADJ;
      end
    end
  end

  // The accumulator rotates work on the accumulator, the prefixed ones on the operand.
  assign rot_src = (command == ebalu_pkg::CMD_RLCA || command == ebalu_pkg::CMD_RRCA ||
                    command == ebalu_pkg::CMD_RLA  || command == ebalu_pkg::CMD_RRA)
                   ? accumulator : operand_value;

  assign bit_mask = 8'h01 << bit_index;

  always_comb begin
    r     = accumulator;
    fz    = flags_in[ebalu_pkg::FLAG_Z];
    fn    = fin_n;
    fh    = fin_h;
    fc    = cin;
    wb    = 1'b1;
    zcalc = 1'b1;
    unique case (ebalu_pkg::cmd_t'(command))
      ebalu_pkg::CMD_ADD, ebalu_pkg::CMD_ADC: begin
        r  = sum9[7:0];
        fn = 1'b0;
        fh = sum_lo[4];
        fc = sum9[8];
      end
      ebalu_pkg::CMD_SUB, ebalu_pkg::CMD_SBC: begin
        r  = diff9[7:0];
        fn = 1'b1;
        fh = diff_lo[4];
        fc = diff9[8];
      end
      ebalu_pkg::CMD_CP: begin
        // Flags come from the difference, while the accumulator is left as it was.
        r     = accumulator;
        zcalc = 1'b0;
        fz    = (diff9[7:0] == 8'h00);
        fn    = 1'b1;
        fh    = diff_lo[4];
        fc    = diff9[8];
        wb    = 1'b0;
      end
      ebalu_pkg::CMD_AND: begin
        r  = accumulator & operand_value;
        fn = 1'b0;
        fh = 1'b1;
        fc = 1'b0;
      end
      ebalu_pkg::CMD_OR: begin
        r  = accumulator | operand_value;
        fn = 1'b0;
        fh = 1'b0;
        fc = 1'b0;
      end
      ebalu_pkg::CMD_XOR: begin
        r  = accumulator ^ operand_value;
        fn = 1'b0;
        fh = 1'b0;
        fc = 1'b0;
      end
      ebalu_pkg::CMD_INC: begin
        r  = operand_value + 8'd1;
        fn = 1'b0;
        fh = (operand_value[3:0] == 4'hF);
      end
      ebalu_pkg::CMD_DEC: begin
        r  = operand_value - 8'd1;
        fn = 1'b1;
        fh = (operand_value[3:0] == 4'h0);
      end
      ebalu_pkg::CMD_RLC, ebalu_pkg::CMD_RLCA: begin
        r  = {rot_src[6:0], rot_src[7]};
        fn = 1'b0;
        fh = 1'b0;
        fc = rot_src[7];
      end
      ebalu_pkg::CMD_RRC, ebalu_pkg::CMD_RRCA: begin
        r  = {rot_src[0], rot_src[7:1]};
        fn = 1'b0;
        fh = 1'b0;
        fc = rot_src[0];
      end
      ebalu_pkg::CMD_RL, ebalu_pkg::CMD_RLA: begin
        r  = {rot_src[6:0], cin};
        fn = 1'b0;
        fh = 1'b0;
        fc = rot_src[7];
      end
      ebalu_pkg::CMD_RR, ebalu_pkg::CMD_RRA: begin
        r  = {cin, rot_src[7:1]};
        fn = 1'b0;
        fh = 1'b0;
        fc = rot_src[0];
      end
      ebalu_pkg::CMD_SLA: begin
        r  = {operand_value[6:0], 1'b0};
        fn = 1'b0;
        fh = 1'b0;
        fc = operand_value[7];
      end
      ebalu_pkg::CMD_SRA: begin
        r  = {operand_value[7], operand_value[7:1]};
        fn = 1'b0;
        fh = 1'b0;
        fc = operand_value[0];
      end
      ebalu_pkg::CMD_SRL: begin
        r  = {1'b0, operand_value[7:1]};
        fn = 1'b0;
        fh = 1'b0;
        fc = operand_value[0];
      end
      ebalu_pkg::CMD_SWAP: begin
        r  = {operand_value[3:0], operand_value[7:4]};
        fn = 1'b0;
        fh = 1'b0;
        fc = 1'b0;
      end
      ebalu_pkg::CMD_BIT: begin
        r     = operand_value;
        zcalc = 1'b0;
        fz    = ((operand_value & bit_mask) == 8'h00);
        fn    = 1'b0;
        fh    = 1'b1;
        wb    = 1'b0;
      end
      ebalu_pkg::CMD_SET: begin
        r     = operand_value | bit_mask;
        zcalc = 1'b0;
      end
      ebalu_pkg::CMD_RES: begin
        r     = operand_value & ~bit_mask;
        zcalc = 1'b0;
      end
      ebalu_pkg::CMD_DAA: begin
        r  = fin_n ? (accumulator - daa_adj) : (accumulator + daa_adj);
        fh = 1'b0;
        fc = daa_carry;
      end
      ebalu_pkg::CMD_CPL: begin
        r     = ~accumulator;
        zcalc = 1'b0;
        fn    = 1'b1;
        fh    = 1'b1;
      end
      ebalu_pkg::CMD_CCF: begin
        zcalc = 1'b0;
        fn    = 1'b0;
        fh    = 1'b0;
        fc    = ~cin;
      end
      ebalu_pkg::CMD_SCF: begin
        zcalc = 1'b0;
        fn    = 1'b0;
        fh    = 1'b0;
        fc    = 1'b1;
      end
      default: begin
        // Unused codes leave everything as it was and store nothing.
        zcalc = 1'b0;
        wb    = 1'b0;
      end
    endcase
    // The accumulator rotates always clear Z.
    if (command == ebalu_pkg::CMD_RLCA || command == ebalu_pkg::CMD_RRCA ||
        command == ebalu_pkg::CMD_RLA  || command == ebalu_pkg::CMD_RRA) begin
      zcalc = 1'b0;
      fz    = 1'b0;
    end
    if (zcalc) begin
      fz = (r == 8'h00);
    end
  end

  assign res.result     = r;
  assign res.flags      = {fz, fn, fh, fc};
  assign res.write_back = wb;

endmodule

### design/eight_bit_alu_with_flags_top.sv
// Eight-bit ALU with flags: input register, combinational datapath and result register.
// An accepted request passes through the input register and then the result register.
// Throughput: one request per cycle while the result side is not stalled.
// The output register and input register decouple the two sides, so a stalled result
// still leaves one slot for a new request.
// Reset clears the valid flags of both register stages; the payload registers keep their data.
`include "eight_bit_alu_with_flags_top_defines.svh"

module eight_bit_alu_with_flags_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] command,
  input  logic [7:0] accumulator,
  input  logic [7:0] operand_value,
  input  logic [7:0] flags_in,
  input  logic [2:0] bit_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] result_value,
  output logic [7:0] flags_out,
  output logic       write_back
);

  logic                s1_valid;
  logic [4:0]          s1_command;
  logic [7:0]          s1_accumulator;
  logic [7:0]          s1_operand;
  logic [7:0]          s1_flags;
  logic [2:0]          s1_bit_index;
  logic                s2_load;
  logic                s1_advance;
  logic                in_take;
  ebalu_pkg::alu_res_t alu_res;
  logic [3:0]          flags_hi;

  assign s2_load    = !out_valid || !out_stall;
  assign s1_advance = s1_valid && s2_load;
  assign in_stall   = s1_valid && !s2_load;
  assign in_take    = in_valid && !in_stall;

  ebalu_core u_core (
    .command       (s1_command),
    .accumulator   (s1_accumulator),
    .operand_value (s1_operand),
    .flags_in      (s1_flags),
    .bit_index     (s1_bit_index),
    .res           (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (s2_load) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_command     <= command;
      s1_accumulator <= accumulator;
      s1_operand     <= operand_value;
      s1_flags       <= flags_in;
      s1_bit_index   <= bit_index;
    end
    if (s1_advance) begin
      result_value <= alu_res.result;
      flags_hi     <= alu_res.flags;
      write_back   <= alu_res.write_back;
    end
  end

  assign flags_out = {flags_hi, 4'h0};

  `EBALU_ASSERT_NEXT(a_advance_fills_out, s1_advance, out_valid, "request missed the output")
  `EBALU_ASSERT_NOW(a_stall_only_when_full, in_stall, s1_valid, "stall with empty input stage")
  `EBALU_ASSERT_NOW(a_no_overwrite, in_take && s1_valid, s1_advance, "input stage overwritten")
  `EBALU_ASSERT_NEXT(a_hold_when_blocked, s1_valid && !s2_load, s1_valid, "blocked request lost")

endmodule

### dv/alu_flags_checker.sv
// Checker for the eight-bit ALU: predicts each accepted request and compares the results.
`timescale 1ns / 100ps

module alu_flags_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [4:0] command,
  input  logic [7:0] accumulator,
  input  logic [7:0] operand_value,
  input  logic [7:0] flags_in,
  input  logic [2:0] bit_index,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] result_value,
  input  logic [7:0] flags_out,
  input  logic       write_back,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [4:0] cmd;
    logic [7:0] value;
    logic [7:0] flags;
    logic       wb;
  } alu_result_t;

  alu_result_t alu_results_q[$];
  int          mismatches = 0;

  function automatic alu_result_t predict_alu(input logic [4:0] cmd, input logic [7:0] a,
                                              input logic [7:0] n, input logic [7:0] f,
                                              input logic [2:0] b);
    alu_result_t res;
    logic [8:0]  wide;
    logic [7:0]  src;
    logic [7:0]  mask;
    logic        z, sub, half, carry, cin, ci, daa_c;
    cin       = f[ebalu_pkg::FLAG_C];
    z         = f[ebalu_pkg::FLAG_Z];
    sub       = f[ebalu_pkg::FLAG_N];
    half      = f[ebalu_pkg::FLAG_H];
    carry     = f[ebalu_pkg::FLAG_C];
    mask      = 8'h01 << b;
    res.cmd   = cmd;
    res.value = a;
    res.wb    = 1'b1;
    unique case (cmd)
      ebalu_pkg::CMD_ADD, ebalu_pkg::CMD_ADC: begin
        ci        = (cmd == ebalu_pkg::CMD_ADC) ? cin : 1'b0;
        wide      = {1'b0, a} + {1'b0, n} + ci;
        res.value = wide[7:0];
        z         = (wide[7:0] == 8'h00);
        sub       = 1'b0;
        half      = ({1'b0, a[3:0]} + {1'b0, n[3:0]} + ci) > 5'h0F;
        carry     = wide[8];
      end
      ebalu_pkg::CMD_SUB, ebalu_pkg::CMD_SBC, ebalu_pkg::CMD_CP: begin
        ci        = (cmd == ebalu_pkg::CMD_SBC) ? cin : 1'b0;
        wide      = {1'b0, a} - {1'b0, n} - ci;
        res.value = wide[7:0];
        z         = (wide[7:0] == 8'h00);
        sub       = 1'b1;
        half      = ({1'b0, n[3:0]} + ci) > {1'b0, a[3:0]};
        carry     = ({1'b0, n} + ci) > {1'b0, a};
        // A compare sets the flags of the subtraction but keeps the accumulator.
        if (cmd == ebalu_pkg::CMD_CP) begin
          res.value = a;
          res.wb    = 1'b0;
        end
      end
      ebalu_pkg::CMD_AND, ebalu_pkg::CMD_OR, ebalu_pkg::CMD_XOR: begin
        if (cmd == ebalu_pkg::CMD_AND) res.value = a & n;
        else if (cmd == ebalu_pkg::CMD_OR) res.value = a | n;
        else res.value = a ^ n;
        z     = (res.value == 8'h00);
        sub   = 1'b0;
        half  = (cmd == ebalu_pkg::CMD_AND);
        carry = 1'b0;
      end
      ebalu_pkg::CMD_INC, ebalu_pkg::CMD_DEC: begin
        res.value = (cmd == ebalu_pkg::CMD_INC) ? n + 8'h01 : n - 8'h01;
        z         = (res.value == 8'h00);
        sub       = (cmd == ebalu_pkg::CMD_DEC);
        half      = (cmd == ebalu_pkg::CMD_INC) ? (n[3:0] == 4'hF) : (n[3:0] == 4'h0);
      end
      ebalu_pkg::CMD_RLC, ebalu_pkg::CMD_RLCA, ebalu_pkg::CMD_RL, ebalu_pkg::CMD_RLA: begin
        src       = (cmd == ebalu_pkg::CMD_RLCA || cmd == ebalu_pkg::CMD_RLA) ? a : n;
        res.value = (cmd == ebalu_pkg::CMD_RLC || cmd == ebalu_pkg::CMD_RLCA)
                    ? {src[6:0], src[7]} : {src[6:0], cin};
        z         = (cmd == ebalu_pkg::CMD_RLC || cmd == ebalu_pkg::CMD_RL) &&
                    (res.value == 8'h00);
        sub       = 1'b0;
        half      = 1'b0;
        carry     = src[7];
      end
      ebalu_pkg::CMD_RRC, ebalu_pkg::CMD_RRCA, ebalu_pkg::CMD_RR, ebalu_pkg::CMD_RRA: begin
        src       = (cmd == ebalu_pkg::CMD_RRCA || cmd == ebalu_pkg::CMD_RRA) ? a : n;
        res.value = (cmd == ebalu_pkg::CMD_RRC || cmd == ebalu_pkg::CMD_RRCA)
                    ? {src[0], src[7:1]} : {cin, src[7:1]};
        z         = (cmd == ebalu_pkg::CMD_RRC || cmd == ebalu_pkg::CMD_RR) &&
                    (res.value == 8'h00);
        sub       = 1'b0;
        half      = 1'b0;
        carry     = src[0];
      end
      ebalu_pkg::CMD_SLA, ebalu_pkg::CMD_SRA, ebalu_pkg::CMD_SRL, ebalu_pkg::CMD_SWAP: begin
        unique case (cmd)
          ebalu_pkg::CMD_SLA: res.value = {n[6:0], 1'b0};
          ebalu_pkg::CMD_SRA: res.value = {n[7], n[7:1]};
          ebalu_pkg::CMD_SRL: res.value = {1'b0, n[7:1]};
          default:            res.value = {n[3:0], n[7:4]};
        endcase
        z     = (res.value == 8'h00);
        sub   = 1'b0;
        half  = 1'b0;
        carry = (cmd == ebalu_pkg::CMD_SLA) ? n[7] : (cmd == ebalu_pkg::CMD_SWAP) ? 1'b0 : n[0];
      end
      ebalu_pkg::CMD_BIT: begin
        res.value = n;
        res.wb    = 1'b0;
        z         = ~n[b];
        sub       = 1'b0;
        half      = 1'b1;
      end
      ebalu_pkg::CMD_SET: res.value = n | mask;
      ebalu_pkg::CMD_RES: res.value = n & ~mask;
      ebalu_pkg::CMD_DAA: begin
        wide  = {1'b0, a};
        daa_c = cin;
        if (!f[ebalu_pkg::FLAG_N]) begin
          if (cin || a > ebalu_pkg::DAA_LIMIT) begin
            wide  = wide + ebalu_pkg::DAA_HIGH_ADJ;
            daa_c = 1'b1;
          end
          if (f[ebalu_pkg::FLAG_H] || a[3:0] > ebalu_pkg::DIGIT_MAX) begin
            wide = wide + ebalu_pkg::DAA_LOW_ADJ;
          end
        end else begin
          if (cin) wide = wide - ebalu_pkg::DAA_HIGH_ADJ;
          if (f[ebalu_pkg::FLAG_H]) wide = wide - ebalu_pkg::DAA_LOW_ADJ;
        end
        res.value = wide[7:0];
        z         = (wide[7:0] == 8'h00);
        half      = 1'b0;
        carry     = daa_c;
      end
      ebalu_pkg::CMD_CPL: begin
        res.value = ~a;
        sub       = 1'b1;
        half      = 1'b1;
      end
      ebalu_pkg::CMD_CCF, ebalu_pkg::CMD_SCF: begin
        sub   = 1'b0;
        half  = 1'b0;
        carry = (cmd == ebalu_pkg::CMD_SCF) ? 1'b1 : ~cin;
      end
      // Unused codes do nothing and store nothing.
      default: res.wb = 1'b0;
    endcase
    res.flags = {z, sub, half, carry, 4'h0};
    return res;
  endfunction

  function automatic int check_field(input string name, input logic [4:0] cmd,
                                     input logic [7:0] want, input logic [7:0] got);
    if (got === want) return 0;
    $display("%0t: %s mismatch for command %0d, expected %h, actual %h",
             $time, name, cmd, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    alu_result_t want;
    if (rst) begin
      alu_results_q.delete();
    end else begin
      // A result leaves only after its request has passed the input register, so the pop comes before the push.
      if (out_valid && !out_stall) begin
        if (alu_results_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request outstanding, expected none, actual %h/%h/%b",
                   $time, result_value, flags_out, write_back);
        end else begin
          want = alu_results_q.pop_front();
          mismatches += check_field("result_value", want.cmd, want.value, result_value);
          mismatches += check_field("flags_out", want.cmd, want.flags, flags_out);
          mismatches += check_field("write_back", want.cmd, {7'b0, want.wb}, {7'b0, write_back});
        end
      end
      if (in_valid && !in_stall) begin
        alu_results_q.push_back(predict_alu(command, accumulator, operand_value, flags_in,
                                            bit_index));
      end
    end
    fail_count <= mismatches;
    pending    <= alu_results_q.size();
  end

endmodule

### dv/tb.sv
// Testbench top for the eight-bit ALU: clock, reset, request stimulus and the verdict.
`timescale 1ns / 100ps

module tb;

  localparam int NUM_CODES = 32;

  logic       clk;
  logic       rst           = 1'b1;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [4:0] command       = '0;
  logic [7:0] accumulator   = '0;
  logic [7:0] operand_value = '0;
  logic [7:0] flags_in      = '0;
  logic [2:0] bit_index     = '0;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic [7:0] result_value;
  logic [7:0] flags_out;
  logic       write_back;
  int         fail_count;
  int         pending;

  logic       gap_enable    = 1'b0;
  logic       stall_enable  = 1'b0;
  int         stall_left    = 0;
  int         requests_sent = 0;
  logic [7:0] corner_bytes [4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};
  logic [7:0] corner_flags [4] = '{8'hF0, 8'h00, 8'h5A, 8'hA5};

  eight_bit_alu_with_flags_top dut (.*);
  alu_flags_checker            checker_i (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Result stalls come in bursts of random length.
  always @(posedge clk) begin
    if (!stall_enable) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_request(input logic [4:0] cmd, input logic [7:0] a, input logic [7:0] n,
                              input logic [7:0] f, input logic [2:0] b);
    int gap;
    if (gap_enable && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command       <= cmd;
    accumulator   <= a;
    operand_value <= n;
    flags_in      <= f;
    bit_index     <= b;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    unique case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h0F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_bcd();
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  // Mostly independent requests; now and then a BCD add or subtract followed by its
  // decimal adjust, fed with the flags that the arithmetic would leave behind.
  task automatic send_random;
    logic [7:0] a, n;
    logic [8:0] s;
    logic       h;
    if ($urandom_range(0, 11) == 0) begin
      a = pick_bcd();
      n = pick_bcd();
      if ($urandom_range(0, 1) == 1) begin
        s = {1'b0, a} + {1'b0, n};
        h = ({1'b0, a[3:0]} + {1'b0, n[3:0]}) > 5'h0F;
        push_request(ebalu_pkg::CMD_ADD, a, n, 8'($urandom), 3'($urandom));
        push_request(ebalu_pkg::CMD_DAA, s[7:0], n,
                     {s[7:0] == 8'h00, 1'b0, h, s[8], 4'($urandom)}, 3'($urandom));
      end else begin
        s = {1'b0, a} - {1'b0, n};
        h = n[3:0] > a[3:0];
        push_request(ebalu_pkg::CMD_SUB, a, n, 8'($urandom), 3'($urandom));
        push_request(ebalu_pkg::CMD_DAA, s[7:0], n,
                     {s[7:0] == 8'h00, 1'b1, h, n > a, 4'($urandom)}, 3'($urandom));
      end
    end else begin
      push_request(5'($urandom_range(0, NUM_CODES - 1)), pick_byte(), pick_byte(),
                   8'($urandom), 3'($urandom));
    end
  endtask

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Every code, unused ones included, with corner operands.
    for (int code = 0; code < NUM_CODES; code++) begin
      push_request(5'(code), corner_bytes[code % 4], corner_bytes[(code / 4) % 4],
                   corner_flags[(code / 2) % 4], 3'(code));
    end
    push_request(ebalu_pkg::CMD_DAA, 8'h9A, 8'h00, 8'h00, 3'd0);
    push_request(ebalu_pkg::CMD_DAA, 8'h00, 8'h00, 8'h70, 3'd0);
    push_request(ebalu_pkg::CMD_CP, 8'h42, 8'h42, 8'h00, 3'd0);
    push_request(ebalu_pkg::CMD_BIT, 8'h00, 8'h7F, 8'h10, 3'd7);
    push_request(ebalu_pkg::CMD_SBC, 8'h00, 8'hFF, 8'h10, 3'd0);
    push_request(ebalu_pkg::CMD_ADC, 8'hFF, 8'h00, 8'h10, 3'd0);
    drain_results();

    gap_enable = 1'b1;
    stall_enable <= 1'b1;
    repeat (720) send_random();
    drain_results();

    gap_enable = 1'b0;
    stall_enable <= 1'b0;
    repeat (250) send_random();

    gap_enable = 1'b1;
    stall_enable <= 1'b1;
    repeat (450) send_random();
    drain_results();

    // Back-to-back traffic to the end.
    gap_enable = 1'b0;
    stall_enable <= 1'b0;
    repeat (250) send_random();
    in_valid <= 1'b0;

    waited = 0;
    @(posedge clk);
    while (pending != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);

    $display("Summary: %0d requests over all %0d command codes, corners first, then random",
             requests_sent, NUM_CODES);
    $display("operands with BCD adjust sequences, bursty gaps and stalls, and drain pauses.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

endmodule
